/* rtl/pscc_pkg.sv */
// Shared types, codes and DigestInfo prefix tables for the PKCS#1 v1.5
// signature block checker. No dependencies.
package pscc_pkg;

  localparam int NUM_KINDS    = 6;
  localparam int PREFIX_MAX   = 19;
  localparam int MIN_TAIL     = 20;
  localparam int QUEUE_DEPTH  = 4;
  localparam int RESULT_DEPTH = 2;

  localparam logic [7:0] HDR_BYTE0 = 8'h00;
  localparam logic [7:0] HDR_BYTE1 = 8'h01;
  localparam logic [7:0] PAD_BYTE  = 8'hFF;
  localparam logic [7:0] SEP_BYTE  = 8'h00;

  localparam logic [1:0] VERDICT_VALID       = 2'd0;
  localparam logic [1:0] VERDICT_FAILED      = 2'd1;
  localparam logic [1:0] VERDICT_UNSUPPORTED = 2'd2;

  localparam logic [2:0] KIND_NONE   = 3'd0;
  localparam logic [2:0] KIND_MD2    = 3'd1;
  localparam logic [2:0] KIND_MD5    = 3'd2;
  localparam logic [2:0] KIND_SHA1   = 3'd3;
  localparam logic [2:0] KIND_SHA256 = 3'd4;
  localparam logic [2:0] KIND_SHA384 = 3'd5;
  localparam logic [2:0] KIND_SHA512 = 3'd6;

  localparam logic [2:0] KIND_OF [NUM_KINDS] = '{
    KIND_MD2, KIND_MD5, KIND_SHA1, KIND_SHA256, KIND_SHA384, KIND_SHA512
  };

  localparam logic [4:0] PREFIX_LEN [NUM_KINDS] = '{5'd18, 5'd18, 5'd15, 5'd19, 5'd19, 5'd19};
  localparam logic [6:0] DIGEST_LEN [NUM_KINDS] = '{7'd16, 7'd16, 7'd20, 7'd32, 7'd48, 7'd64};

  localparam logic [7:0] PREFIX_TAB [NUM_KINDS][PREFIX_MAX] = '{
    '{8'h30, 8'h20, 8'h30, 8'h0c, 8'h06, 8'h08, 8'h2a, 8'h86, 8'h48, 8'h86,
      8'hf7, 8'h0d, 8'h02, 8'h02, 8'h05, 8'h00, 8'h04, 8'h10, 8'h00},
    '{8'h30, 8'h20, 8'h30, 8'h0c, 8'h06, 8'h08, 8'h2a, 8'h86, 8'h48, 8'h86,
      8'hf7, 8'h0d, 8'h02, 8'h05, 8'h05, 8'h00, 8'h04, 8'h10, 8'h00},
    '{8'h30, 8'h21, 8'h30, 8'h09, 8'h06, 8'h05, 8'h2b, 8'h0e, 8'h03, 8'h02,
      8'h1a, 8'h05, 8'h00, 8'h04, 8'h14, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h30, 8'h31, 8'h30, 8'h0d, 8'h06, 8'h09, 8'h60, 8'h86, 8'h48, 8'h01,
      8'h65, 8'h03, 8'h04, 8'h02, 8'h01, 8'h05, 8'h00, 8'h04, 8'h20},
    '{8'h30, 8'h41, 8'h30, 8'h0d, 8'h06, 8'h09, 8'h60, 8'h86, 8'h48, 8'h01,
      8'h65, 8'h03, 8'h04, 8'h02, 8'h02, 8'h05, 8'h00, 8'h04, 8'h30},
    '{8'h30, 8'h51, 8'h30, 8'h0d, 8'h06, 8'h09, 8'h60, 8'h86, 8'h48, 8'h01,
      8'h65, 8'h03, 8'h04, 8'h02, 8'h03, 8'h05, 8'h00, 8'h04, 8'h40}
  };

  // Block parse state, one-hot.
  typedef enum logic [3:0] {
    PH_HDR0 = 4'b0001,
    PH_HDR1 = 4'b0010,
    PH_PAD  = 4'b0100,
    PH_TAIL = 4'b1000
  } phase_t;

  // Digest store operation carried by a queued word.
  typedef enum logic [1:0] {
    OP_NONE  = 2'd0,
    OP_WRITE = 2'd1,
    OP_CMP   = 2'd2
  } op_t;

  // Word passed from the classifier to the executing back end.
  typedef struct packed {
    op_t        op;
    logic [5:0] addr;
    logic       addr_bad;   // digest index beyond the store
    logic [7:0] data;
    logic       last;
    logic       pre_fail;   // structure or short-tail failure
    logic [2:0] kind;
    logic       len_bad;
  } entry_t;

  typedef struct packed {
    logic [1:0] verdict;
    logic [2:0] kind;
  } result_t;

endpackage

/* rtl/pscc_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module pscc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* rtl/pscc_fifo.sv */
// Small register FIFO with first-word-fall-through head.
// No dependencies.
module pscc_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!do_push && do_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

endmodule

/* rtl/pscc_front.sv */
// Front end: accepts bytes, parses header/padding/prefix, and queues digest
// store operations plus the verdict ingredients. Depends on pscc_pkg.
module pscc_front #(
  parameter int MAX_BLOCK_BYTES  = 512,
  parameter int MAX_DIGEST_BYTES = 64
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            accept,
  input  logic            mode,
  input  logic [7:0]      data_byte,
  input  logic            last_flag,
  input  logic            q_full,
  output logic            q_push,
  output pscc_pkg::entry_t q_din
);

  import pscc_pkg::*;

  localparam int TW  = $clog2(MAX_BLOCK_BYTES + 1);
  localparam int WPW = $clog2(MAX_DIGEST_BYTES + 1);

  phase_t                 phase_r, phase_nxt;
  logic                   fail_r, fail_nxt;
  logic [NUM_KINDS-1:0]   cand_r, cand_nxt;
  logic [TW-1:0]          tail_r, tail_nxt;
  logic [WPW-1:0]         wr_ptr_r, wr_ptr_nxt;

  always_comb begin
    logic [TW-1:0] doff;
    logic [TW-1:0] dsel;
    logic          found;
    logic          ok;

    phase_nxt  = phase_r;
    fail_nxt   = fail_r;
    cand_nxt   = cand_r;
    tail_nxt   = tail_r;
    wr_ptr_nxt = wr_ptr_r;
    q_push     = 1'b0;
    q_din      = '0;
    q_din.op   = OP_NONE;
    doff       = '0;
    dsel       = '0;
    found      = 1'b0;
    ok         = 1'b0;

    if (accept) begin
      if (!mode) begin
        // Load the expected digest; drop bytes past the store.
        if (wr_ptr_r < WPW'(MAX_DIGEST_BYTES)) begin
          q_push     = 1'b1;
          q_din.op   = OP_WRITE;
          q_din.addr = 6'(wr_ptr_r);
          q_din.data = data_byte;
          wr_ptr_nxt = wr_ptr_r + 1'b1;
        end
      end else begin
        q_din.data = data_byte;
        if (!fail_r) begin
          case (phase_r)
            PH_HDR0: begin
              if (data_byte != HDR_BYTE0) fail_nxt = 1'b1;
              else phase_nxt = PH_HDR1;
            end
            PH_HDR1: begin
              if (data_byte != HDR_BYTE1) fail_nxt = 1'b1;
              else phase_nxt = PH_PAD;
            end
            PH_PAD: begin
              if (data_byte == SEP_BYTE) phase_nxt = PH_TAIL;
              else if (data_byte != PAD_BYTE) fail_nxt = 1'b1;
            end
            PH_TAIL: begin
              // Survivors past the second tail byte share one prefix length,
              // so a single digest index serves every live candidate.
              for (int c = NUM_KINDS - 1; c >= 0; c--) begin
                if (cand_r[c]) begin
                  if (tail_r < TW'(PREFIX_LEN[c])) begin
                    if (PREFIX_TAB[c][tail_r[4:0]] != data_byte) cand_nxt[c] = 1'b0;
                  end else begin
                    doff = tail_r - TW'(PREFIX_LEN[c]);
                    if (doff < TW'(DIGEST_LEN[c])) begin
                      found = 1'b1;
                      dsel  = doff;
                    end
                  end
                end
              end
              if (found) begin
                q_push         = 1'b1;
                q_din.op       = OP_CMP;
                q_din.addr     = dsel[5:0];
                q_din.addr_bad = (dsel >= TW'(MAX_DIGEST_BYTES));
              end
              if (tail_r < TW'(MAX_BLOCK_BYTES)) tail_nxt = tail_r + 1'b1;
            end
            default: fail_nxt = 1'b1;
          endcase
        end

        if (last_flag) begin
          ok = !fail_nxt && (phase_nxt == PH_TAIL) && (tail_nxt >= TW'(MIN_TAIL));
          q_push         = 1'b1;
          q_din.last     = 1'b1;
          q_din.pre_fail = !ok;
          q_din.kind     = KIND_NONE;
          if (ok) begin
            // Lowest-numbered surviving candidate wins.
            for (int c = NUM_KINDS - 1; c >= 0; c--) begin
              if (cand_nxt[c]) begin
                q_din.kind    = KIND_OF[c];
                q_din.len_bad = (tail_nxt != (TW'(PREFIX_LEN[c]) + TW'(DIGEST_LEN[c])));
              end
            end
          end
          phase_nxt  = PH_HDR0;
          fail_nxt   = 1'b0;
          cand_nxt   = '1;
          tail_nxt   = '0;
          wr_ptr_nxt = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HDR0;
      fail_r   <= 1'b0;
      cand_r   <= '1;
      tail_r   <= '0;
      wr_ptr_r <= '0;
    end else begin
      phase_r  <= phase_nxt;
      fail_r   <= fail_nxt;
      cand_r   <= cand_nxt;
      tail_r   <= tail_nxt;
      wr_ptr_r <= wr_ptr_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && mode && last_flag) |=> (tail_r == '0 && phase_r == PH_HDR0 && cand_r == '1))
    else $error("block state not cleared after last byte");

  a_one_prefix_group: assert property (@(posedge clk) disable iff (!rst_n)
    (tail_r >= TW'(2)) |-> !(cand_r[2] && ((cand_r & 6'b111011) != '0))
      && !((cand_r[1:0] != '0) && (cand_r[5:3] != '0)))
    else $error("candidates with different prefix lengths survive");

  a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("push into a full queue");
`endif

endmodule

/* rtl/pscc_back.sv */
// Back end: executes queued digest store writes and compares, accumulates
// mismatches and forms the verdict. Depends on pscc_pkg and pscc_ram.
module pscc_back #(
  parameter int MAX_DIGEST_BYTES = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_empty,
  input  pscc_pkg::entry_t  q_dout,
  output logic              q_pop,
  input  logic              res_full,
  output logic              res_push,
  output pscc_pkg::result_t res_din
);

  import pscc_pkg::*;

  localparam int AW = $clog2(MAX_DIGEST_BYTES);

  entry_t     s1_r;
  logic       s1_valid_r, s1_valid_nxt;
  logic       mism_r, mism_nxt;
  logic       s1_done, can_load;
  logic       ram_we, ram_re;
  logic [7:0] ram_q;
  logic       mism_now;

  assign s1_done  = s1_valid_r && (!s1_r.last || !res_full);
  assign can_load = !s1_valid_r || s1_done;
  assign q_pop    = !q_empty && can_load;
  assign ram_we   = q_pop && (q_dout.op == OP_WRITE);
  assign ram_re   = q_pop && (q_dout.op == OP_CMP) && !q_dout.addr_bad;

  pscc_ram #(
    .WIDTH (8),
    .DEPTH (MAX_DIGEST_BYTES)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (q_dout.addr[AW-1:0]),
    .wdata (q_dout.data),
    .re    (ram_re),
    .raddr (q_dout.addr[AW-1:0]),
    .rdata (ram_q)
  );

  assign mism_now = (s1_r.op == OP_CMP) && (s1_r.addr_bad || (ram_q != s1_r.data));

  always_comb begin
    s1_valid_nxt = q_pop || (s1_valid_r && !s1_done);
    mism_nxt     = mism_r;
    res_push     = 1'b0;
    res_din      = '0;
    if (s1_done) begin
      if (s1_r.last) begin
        res_push = 1'b1;
        mism_nxt = 1'b0;
        if (s1_r.pre_fail) begin
          res_din.verdict = VERDICT_FAILED;
          res_din.kind    = KIND_NONE;
        end else if (s1_r.kind == KIND_NONE) begin
          res_din.verdict = VERDICT_UNSUPPORTED;
          res_din.kind    = KIND_NONE;
        end else begin
          res_din.verdict = (s1_r.len_bad || mism_r || mism_now) ? VERDICT_FAILED
                                                                 : VERDICT_VALID;
          res_din.kind    = s1_r.kind;
        end
      end else begin
        mism_nxt = mism_r || mism_now;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      mism_r     <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      mism_r     <= mism_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      s1_r <= q_dout;
    end
  end

`ifndef NO_ASSERTIONS
  a_result_only_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> (s1_valid_r && s1_r.last && !res_full))
    else $error("result formed for a non-final word");

  a_hold_blocks_pop: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_done) |-> !q_pop)
    else $error("queue popped while stage is held");

  a_mism_clear_after_result: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |=> !mism_r)
    else $error("mismatch flag survives a verdict");
`endif

endmodule

/* rtl/pkcs1_signature_block_checker.sv */
// Top level of the PKCS#1 v1.5 signature block checker.
// Depends on pscc_pkg, pscc_front, pscc_fifo, pscc_back, pscc_ram.

// Streams one byte per word. With in_mode low the byte is loaded as the next
// expected digest byte (bytes past MAX_DIGEST_BYTES are dropped). With in_mode
// high the byte belongs to the recovered encoded block, most significant
// first: 00 01, FF padding, 00 separator, a DigestInfo prefix (MD2, MD5,
// SHA-1, SHA-256, SHA-384, SHA-512), then the digest. A block byte with
// in_last_flag set yields exactly one result word: out_verdict (0 valid,
// 1 failed, 2 unsupported prefix) and out_hash_kind (0 none, 1..6 as listed).
// After a verdict the block parse and the digest load pointer restart, so the
// next digest loads from index 0; stored digest bytes are kept. Both sides
// are queues: in_push/in_full and out_pop/out_empty. One byte per clock is
// accepted sustained while the result queue has room, as the compare stage
// retires one queued word per clock (a store write, compare or final word).
// Once two verdicts wait unpopped and a third final byte reaches the compare
// stage, that stage holds, the parser queue fills and in_full rises.
// A verdict passes through the parser queue, the compare stage register and
// the result queue before it reaches the result ports. A four-word queue
// between the parser and the compare stage and a two-word result queue let
// each side stall on its own. No clearing pass is needed after reset.
module pkcs1_signature_block_checker #(
  parameter int MAX_BLOCK_BYTES  = 512,
  parameter int MAX_DIGEST_BYTES = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_push,
  output logic       in_full,
  input  logic       in_mode,
  input  logic [7:0] in_data_byte,
  input  logic       in_last_flag,
  output logic       out_empty,
  input  logic       out_pop,
  output logic [1:0] out_verdict,
  output logic [2:0] out_hash_kind
);

  import pscc_pkg::*;

  logic    accept;
  logic    q_push, q_full, q_pop, q_empty;
  entry_t  q_din, q_dout;
  logic    res_push, res_full;
  result_t res_din, res_dout;

  // Take a word whenever the parser queue has room.
  assign accept  = in_push && !q_full;
  assign in_full = q_full;

  pscc_front #(
    .MAX_BLOCK_BYTES  (MAX_BLOCK_BYTES),
    .MAX_DIGEST_BYTES (MAX_DIGEST_BYTES)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .mode      (in_mode),
    .data_byte (in_data_byte),
    .last_flag (in_last_flag),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_din     (q_din)
  );

  // Decouple the parser from the store and compare stage.
  pscc_fifo #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (q_din),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_dout),
    .empty (q_empty)
  );

  pscc_back #(
    .MAX_DIGEST_BYTES (MAX_DIGEST_BYTES)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_empty  (q_empty),
    .q_dout   (q_dout),
    .q_pop    (q_pop),
    .res_full (res_full),
    .res_push (res_push),
    .res_din  (res_din)
  );

  // Hold finished verdicts until the consumer pops them.
  pscc_fifo #(
    .WIDTH ($bits(result_t)),
    .DEPTH (RESULT_DEPTH)
  ) u_results (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .din   (res_din),
    .full  (res_full),
    .pop   (out_pop),
    .dout  (res_dout),
    .empty (out_empty)
  );

  assign out_verdict   = res_dout.verdict;
  assign out_hash_kind = res_dout.kind;

endmodule

/* tb/tb_pkcs1_signature_block_checker.sv */
`timescale 1ns / 100ps
// Self-checking testbench for pkcs1_signature_block_checker: streams digest loads and
// encoded blocks through the queue ports and checks every verdict against the table or a local model.
// Depends on pscc_pkg and the checker RTL only.

module tb_pkcs1_signature_block_checker;
  import pscc_pkg::*;

  localparam int HALF_PERIOD  = 2;
  localparam int RESET_CYCLES = 12;
  localparam int CYCLE_LIMIT  = 40000;
  localparam int SETTLE       = 16;     // queues are 4 + 2 deep
  localparam int RX_HOLD      = 300;    // long receiver hold-off, in cycles
  localparam int BLOCK_CAP    = 512;    // tail counter saturates here
  localparam int DIGEST_CAP   = 64;     // digest store depth
  localparam int PFX_SPAN     = 19;
  localparam int TAIL_MIN     = 20;
  localparam int NUM_ALGS     = 6;

  // DigestInfo prefixes, in the order MD2, MD5, SHA-1, SHA-256, SHA-384, SHA-512.
  localparam logic [7:0] DI_PREFIX [NUM_ALGS][PFX_SPAN] = '{
    '{8'h30, 8'h20, 8'h30, 8'h0c, 8'h06, 8'h08, 8'h2a, 8'h86, 8'h48, 8'h86,
      8'hf7, 8'h0d, 8'h02, 8'h02, 8'h05, 8'h00, 8'h04, 8'h10, 8'h00},
    '{8'h30, 8'h20, 8'h30, 8'h0c, 8'h06, 8'h08, 8'h2a, 8'h86, 8'h48, 8'h86,
      8'hf7, 8'h0d, 8'h02, 8'h05, 8'h05, 8'h00, 8'h04, 8'h10, 8'h00},
    '{8'h30, 8'h21, 8'h30, 8'h09, 8'h06, 8'h05, 8'h2b, 8'h0e, 8'h03, 8'h02,
      8'h1a, 8'h05, 8'h00, 8'h04, 8'h14, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h30, 8'h31, 8'h30, 8'h0d, 8'h06, 8'h09, 8'h60, 8'h86, 8'h48, 8'h01,
      8'h65, 8'h03, 8'h04, 8'h02, 8'h01, 8'h05, 8'h00, 8'h04, 8'h20},
    '{8'h30, 8'h41, 8'h30, 8'h0d, 8'h06, 8'h09, 8'h60, 8'h86, 8'h48, 8'h01,
      8'h65, 8'h03, 8'h04, 8'h02, 8'h02, 8'h05, 8'h00, 8'h04, 8'h30},
    '{8'h30, 8'h51, 8'h30, 8'h0d, 8'h06, 8'h09, 8'h60, 8'h86, 8'h48, 8'h01,
      8'h65, 8'h03, 8'h04, 8'h02, 8'h03, 8'h05, 8'h00, 8'h04, 8'h40}
  };
  localparam int DI_PREFIX_LEN [NUM_ALGS] = '{18, 18, 15, 19, 19, 19};
  localparam int DI_DIGEST_LEN [NUM_ALGS] = '{16, 16, 20, 32, 48, 64};

  // Ways to damage an otherwise well-formed encoded block.
  typedef enum logic [3:0] {
    FL_NONE,     // well formed
    FL_HDR0,     // first header byte not 00
    FL_HDR1,     // second header byte not 01
    FL_PAD,      // one padding byte neither FF nor 00
    FL_NOSEP,    // block ends inside the padding
    FL_SHORT,    // fewer than 20 bytes after the separator (arg = count)
    FL_PREFIX,   // one prefix byte flipped (arg = position)
    FL_LONG,     // bytes appended after the digest (arg = count)
    FL_TRUNC,    // digest cut short (arg = bytes dropped)
    FL_DIGEST    // one digest byte flipped (arg = position)
  } flaw_t;

  typedef enum logic {ROW_BLOCK, ROW_LOAD} row_t;

  typedef struct packed {
    row_t        row;
    logic [2:0]  alg;      // KIND_* code of the block's algorithm
    int          pad;      // FF padding bytes
    flaw_t       flaw;
    int          arg;      // flaw argument; byte count for a digest load
    logic        typed;    // expected verdict written in the row
    logic [1:0]  verdict;
    logic [2:0]  kind;
  } plan_t;

  // Directed table. Typed rows carry their verdict; the others go to the model.
  localparam int NUM_ROWS = 23;
  localparam plan_t PLAN [NUM_ROWS] = '{
    '{ROW_BLOCK, KIND_SHA512, 8, FL_NONE,   0,   1'b1, VERDICT_VALID,       KIND_SHA512},
    '{ROW_BLOCK, KIND_MD2,    0, FL_NONE,   0,   1'b1, VERDICT_VALID,       KIND_MD2},
    '{ROW_BLOCK, KIND_MD5,    1, FL_NONE,   0,   1'b1, VERDICT_VALID,       KIND_MD5},
    '{ROW_BLOCK, KIND_SHA1,   3, FL_NONE,   0,   1'b1, VERDICT_VALID,       KIND_SHA1},
    '{ROW_BLOCK, KIND_SHA256, 2, FL_NONE,   0,   1'b1, VERDICT_VALID,       KIND_SHA256},
    '{ROW_BLOCK, KIND_SHA384, 5, FL_NONE,   0,   1'b1, VERDICT_VALID,       KIND_SHA384},
    '{ROW_BLOCK, KIND_SHA1,   2, FL_HDR0,   0,   1'b1, VERDICT_FAILED,      KIND_NONE},
    '{ROW_BLOCK, KIND_SHA1,   2, FL_HDR1,   0,   1'b1, VERDICT_FAILED,      KIND_NONE},
    '{ROW_BLOCK, KIND_MD2,    4, FL_PAD,    0,   1'b1, VERDICT_FAILED,      KIND_NONE},
    '{ROW_BLOCK, KIND_SHA1,   3, FL_NOSEP,  0,   1'b1, VERDICT_FAILED,      KIND_NONE},
    '{ROW_BLOCK, KIND_SHA1,   0, FL_NOSEP,  0,   1'b1, VERDICT_FAILED,      KIND_NONE},
    '{ROW_BLOCK, KIND_SHA1,   1, FL_SHORT,  19,  1'b1, VERDICT_FAILED,      KIND_NONE},
    '{ROW_BLOCK, KIND_SHA1,   1, FL_SHORT,  0,   1'b1, VERDICT_FAILED,      KIND_NONE},
    '{ROW_BLOCK, KIND_MD2,    1, FL_PREFIX, 0,   1'b1, VERDICT_UNSUPPORTED, KIND_NONE},
    '{ROW_BLOCK, KIND_MD2,    1, FL_PREFIX, 13,  1'b0, VERDICT_VALID,       KIND_NONE},
    '{ROW_BLOCK, KIND_SHA1,   1, FL_LONG,   1,   1'b1, VERDICT_FAILED,      KIND_SHA1},
    '{ROW_BLOCK, KIND_MD5,    1, FL_TRUNC,  1,   1'b1, VERDICT_FAILED,      KIND_MD5},
    '{ROW_BLOCK, KIND_MD5,    0, FL_DIGEST, 15,  1'b1, VERDICT_FAILED,      KIND_MD5},
    '{ROW_BLOCK, KIND_SHA1,   0, FL_LONG,   3,   1'b1, VERDICT_FAILED,      KIND_SHA1},
    '{ROW_LOAD,  KIND_NONE,   0, FL_NONE,   20,  1'b0, VERDICT_VALID,       KIND_NONE},
    '{ROW_BLOCK, KIND_SHA1,   0, FL_NONE,   0,   1'b0, VERDICT_VALID,       KIND_NONE},
    '{ROW_BLOCK, KIND_MD5,    0, FL_NONE,   0,   1'b0, VERDICT_VALID,       KIND_NONE},
    '{ROW_BLOCK, KIND_SHA1,   2, FL_DIGEST, 0,   1'b0, VERDICT_VALID,       KIND_NONE}
  };

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_push;
  logic       in_full;
  logic       in_mode;
  logic [7:0] in_data_byte;
  logic       in_last_flag;
  logic       out_empty;
  logic       out_pop;
  logic [1:0] out_verdict;
  logic [2:0] out_hash_kind;

  pkcs1_signature_block_checker dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_push       (in_push),
    .in_full       (in_full),
    .in_mode       (in_mode),
    .in_data_byte  (in_data_byte),
    .in_last_flag  (in_last_flag),
    .out_empty     (out_empty),
    .out_pop       (out_pop),
    .out_verdict   (out_verdict),
    .out_hash_kind (out_hash_kind)
  );

  always #HALF_PERIOD clk = ~clk;

  // Model state: parse position of the current block plus the digest store.
  phase_t     parse_ph;
  int         pfx_pos;
  logic [5:0] alive;         // prefix candidates still matching
  int         tail_cnt;
  logic [7:0] ref_digest [DIGEST_CAP];
  int         load_ptr;
  bit         digest_bad;
  bit         frame_bad;

  result_t    pending_verdicts [$];
  int         useful_words = 0;   // words the block acts on (ignored ones excluded)
  int         verdicts_due = 0;
  int         errors = 0;
  int         cycle_count = 0;
  int         snd_idle_pct = 0;
  int         rcv_idle_pct = 0;
  int         hold_requests = 0;

  // Return the block parse and the digest load pointer to their reset values.
  task automatic restart_parse();
    parse_ph   = PH_HDR0;
    pfx_pos    = 0;
    alive      = '1;
    tail_cnt   = 0;
    load_ptr   = 0;
    digest_bad = 1'b0;
    frame_bad  = 1'b0;
  endtask

  // Advance the model by one accepted word; report the verdict it yields, if any.
  task automatic classify_byte(input logic mode, input logic [7:0] b, input logic lst,
                               output bit used, output bit fired, output result_t res);
    int d;
    bit found;
    used  = 1'b0;
    fired = 1'b0;
    res   = '0;
    found = 1'b0;
    if (!mode) begin
      // Drop digest bytes past the end of the store.
      if (load_ptr < DIGEST_CAP) begin
        ref_digest[load_ptr] = b;
        load_ptr++;
        used = 1'b1;
      end
      return;
    end
    // Once the frame is broken only the last byte still matters.
    used = !frame_bad || lst;
    if (!frame_bad) begin
      case (parse_ph)
        PH_HDR0: if (b != HDR_BYTE0) frame_bad = 1'b1; else parse_ph = PH_HDR1;
        PH_HDR1: if (b != HDR_BYTE1) frame_bad = 1'b1; else parse_ph = PH_PAD;
        PH_PAD: begin
          if (b == SEP_BYTE) parse_ph = PH_TAIL;
          else if (b != PAD_BYTE) frame_bad = 1'b1;
        end
        default: begin
          // Each live candidate checks either its prefix or its digest byte.
          for (int c = 0; c < NUM_ALGS; c++) begin
            if (alive[c]) begin
              if (tail_cnt < DI_PREFIX_LEN[c]) begin
                if (pfx_pos < PFX_SPAN && DI_PREFIX[c][pfx_pos] != b) alive[c] = 1'b0;
              end else begin
                d = tail_cnt - DI_PREFIX_LEN[c];
                if (d < DI_DIGEST_LEN[c] && (d >= DIGEST_CAP || ref_digest[d] != b))
                  digest_bad = 1'b1;
              end
            end
          end
          if (pfx_pos < PFX_SPAN) pfx_pos++;
          if (tail_cnt < BLOCK_CAP) tail_cnt++;
        end
      endcase
    end
    if (!lst) return;
    fired       = 1'b1;
    res.verdict = VERDICT_FAILED;
    res.kind    = KIND_NONE;
    if (!frame_bad && parse_ph == PH_TAIL && tail_cnt >= TAIL_MIN) begin
      res.verdict = VERDICT_UNSUPPORTED;
      // The lowest surviving candidate names the algorithm.
      for (int c = 0; c < NUM_ALGS; c++) begin
        if (alive[c] && !found) begin
          found       = 1'b1;
          res.kind    = 3'(KIND_MD2 + c);
          res.verdict = (tail_cnt != DI_PREFIX_LEN[c] + DI_DIGEST_LEN[c] || digest_bad) ?
                        VERDICT_FAILED : VERDICT_VALID;
        end
      end
    end
    restart_parse();
  endtask

  // Offer one word at the falling edge and hold it until the block takes it.
  task automatic send_word(input logic mode, input logic [7:0] b, input logic lst,
                           input bit typed, input result_t want);
    bit used;
    bit fired;
    result_t res;
    @(negedge clk);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_push <= 1'b0;
      @(negedge clk);
    end
    in_push      <= 1'b1;
    in_mode      <= mode;
    in_data_byte <= b;
    in_last_flag <= lst;
    do @(posedge clk); while (in_full);
    classify_byte(mode, b, lst, used, fired, res);
    if (used) useful_words++;
    if (fired) begin
      pending_verdicts.push_back(typed ? want : res);
      verdicts_due++;
    end
  endtask

  // Load n digest bytes; last_pct sets how often last_flag rides along (it must be ignored).
  task automatic load_digest(input int n, input int last_pct);
    repeat (n) send_word(1'b0, 8'($urandom), $urandom_range(99) < last_pct, 1'b0, '0);
  endtask

  // Build one encoded block for alg, damage it as flaw says, and stream it.
  // arg < 0 picks the flaw argument at random.
  task automatic send_block(input logic [2:0] alg, input int pad, input flaw_t flaw,
                            input int arg, input bit typed, input result_t want,
                            input int noise_pct);
    logic [7:0] bq [$];
    int idx;
    int plen;
    int dlen;
    int spot;
    idx  = alg - KIND_MD2;
    plen = DI_PREFIX_LEN[idx];
    dlen = DI_DIGEST_LEN[idx];
    if (arg < 0) begin
      case (flaw)
        FL_SHORT:  arg = $urandom_range(0, TAIL_MIN - 1);
        FL_PREFIX: arg = $urandom_range(0, plen - 1);
        FL_LONG:   arg = $urandom_range(1, 4);
        FL_TRUNC:  arg = $urandom_range(1, dlen);
        FL_DIGEST: arg = $urandom_range(0, dlen - 1);
        default:   arg = 0;
      endcase
    end
    if (flaw == FL_PAD && pad == 0) pad = 1;
    spot = (flaw == FL_PAD) ? $urandom_range(0, pad - 1) : 0;

    bq.push_back(flaw == FL_HDR0 ? 8'($urandom_range(1, 255)) : HDR_BYTE0);
    if (flaw == FL_HDR1) begin
      // Any value but 01: skip over it.
      idx = $urandom_range(0, 254);
      bq.push_back(8'(idx >= HDR_BYTE1 ? idx + 1 : idx));
      idx = alg - KIND_MD2;
    end else begin
      bq.push_back(HDR_BYTE1);
    end
    for (int i = 0; i < pad; i++)
      bq.push_back((flaw == FL_PAD && i == spot) ? 8'($urandom_range(1, 254)) : PAD_BYTE);

    if (flaw != FL_NOSEP) begin
      bq.push_back(SEP_BYTE);
      if (flaw == FL_SHORT) begin
        repeat (arg) bq.push_back(8'($urandom));
      end else begin
        for (int i = 0; i < plen; i++) bq.push_back(DI_PREFIX[idx][i]);
        for (int i = 0; i < dlen; i++) bq.push_back(ref_digest[i]);
        // The prefix starts right after header, padding and separator.
        if (flaw == FL_PREFIX)
          bq[pad + 3 + arg] = bq[pad + 3 + arg] ^ 8'($urandom_range(1, 255));
        if (flaw == FL_DIGEST)
          bq[pad + 3 + plen + arg] = bq[pad + 3 + plen + arg] ^ 8'($urandom_range(1, 255));
        if (flaw == FL_TRUNC) repeat (arg) void'(bq.pop_back());
        if (flaw == FL_LONG) repeat (arg) bq.push_back(8'($urandom));
      end
    end

    // Interleave stray digest loads now and then; they land in the store mid-block.
    for (int i = 0; i < bq.size(); i++) begin
      if ($urandom_range(99) < noise_pct)
        send_word(1'b0, 8'($urandom), 1'($urandom), 1'b0, '0);
      send_word(1'b1, bq[i], i == bq.size() - 1, typed, want);
    end
  endtask

  // Random traffic: mostly well-formed blocks, some damaged, some digest loads and noise.
  task automatic run_random(input int min_words, input int min_verdicts);
    int w0;
    int v0;
    int pick;
    int pad;
    int n;
    logic [2:0] alg;
    flaw_t flaw;
    w0 = useful_words;
    v0 = verdicts_due;
    while (useful_words - w0 < min_words || verdicts_due - v0 < min_verdicts) begin
      pick = $urandom_range(99);
      alg  = 3'($urandom_range(KIND_MD2, KIND_SHA512));
      pad  = ($urandom_range(19) == 0) ? $urandom_range(9, 40) : $urandom_range(0, 8);
      flaw = (pick < 65) ? FL_NONE : flaw_t'($urandom_range(FL_HDR0, FL_DIGEST));
      if (pick < 12) begin
        load_digest($urandom_range(1, DIGEST_CAP + 6), 50);
      end else if (pick < 22) begin
        n = $urandom_range(1, 6);
        for (int i = 0; i < n; i++) send_word(1'b1, 8'($urandom), i == n - 1, 1'b0, '0);
      end else begin
        send_block(alg, pad, flaw, -1, 1'b0, '0, 3);
      end
    end
  endtask

  // Park the input and wait until every predicted verdict is back, then let the pipe settle.
  task automatic wait_for_verdicts();
    @(negedge clk);
    in_push <= 1'b0;
    while (pending_verdicts.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic flag_error(input string what);
    errors++;
    if (errors <= 10) $display("%0t ns: %s", $time, what);
  endtask

  // Receiver: pop at random, or hold off when asked.
  int rx_hold_left = 0;
  int hold_served = 0;
  always @(negedge clk) begin
    if (hold_requests != hold_served) begin
      hold_served  = hold_requests;
      rx_hold_left = RX_HOLD;
    end
    if (rx_hold_left > 0) begin
      rx_hold_left--;
      out_pop <= 1'b0;
    end else begin
      out_pop <= ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  // Check each popped word against the oldest prediction, field by field.
  always @(posedge clk) begin : check_results
    result_t oldest;
    if (rst_n && out_pop && !out_empty) begin
      if (pending_verdicts.size() == 0) begin
        flag_error($sformatf("unexpected result word: verdict %0d kind %0d",
                             out_verdict, out_hash_kind));
      end else begin
        oldest = pending_verdicts.pop_front();
        if (out_verdict !== oldest.verdict || out_hash_kind !== oldest.kind)
          flag_error($sformatf("mismatch: expected verdict %0d kind %0d, got verdict %0d kind %0d",
                               oldest.verdict, oldest.kind, out_verdict, out_hash_kind));
      end
    end
  end

  // Watchdog: stop a hung run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    rst_n        <= 1'b0;
    in_push      <= 1'b0;
    in_mode      <= 1'b0;
    in_data_byte <= 8'h00;
    in_last_flag <= 1'b0;
    for (int i = 0; i < DIGEST_CAP; i++) ref_digest[i] = 8'h00;
    restart_parse();
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Sender mostly busy, receiver stalling about half the time.
    snd_idle_pct = 8;
    rcv_idle_pct = 48;

    // Fill the whole digest store first, so no compare ever reads an unwritten entry;
    // the two bytes past the end must be dropped.
    load_digest(DIGEST_CAP + 2, 0);

    // Walk the directed table.
    for (int i = 0; i < NUM_ROWS; i++) begin
      if (PLAN[i].row == ROW_LOAD)
        load_digest(PLAN[i].arg, 100);
      else
        send_block(PLAN[i].alg, PLAN[i].pad, PLAN[i].flaw, PLAN[i].arg, PLAN[i].typed,
                   result_t'({PLAN[i].verdict, PLAN[i].kind}), 0);
    end
    run_random(20, 1);
    wait_for_verdicts();

    // Swap the roles: sender idles often, receiver rarely.
    snd_idle_pct = 48;
    rcv_idle_pct = 8;

    // Back-pressure: hold the receiver off while single-byte blocks keep coming,
    // so both internal queues fill and in_full rises.
    hold_requests++;
    repeat (40) send_word(1'b1, 8'($urandom), 1'b1, 1'b0, '0);
    wait_for_verdicts();
    run_random(20, 1);
    wait_for_verdicts();

    // Full rate on both sides.
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    run_random(20, 1);
    wait_for_verdicts();

    if (errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule

/* files.f */
rtl/pscc_pkg.sv
rtl/pscc_ram.sv
rtl/pscc_fifo.sv
rtl/pscc_front.sv
rtl/pscc_back.sv
rtl/pkcs1_signature_block_checker.sv
tb/tb_pkcs1_signature_block_checker.sv
